// ===== src/hpr_pkg.sv =====
// ============================================================================
// hpr_pkg
// Shared constants and types for the horizontal polyphase resampler.
// ============================================================================
package hpr_pkg;

    localparam int MAX_TAPS       = 16;
    localparam int MAX_LINE       = 2048;
    localparam int SAMPLE_BITS    = 16;
    localparam int TAP_BITS       = 4;
    localparam int LINE_BITS      = 11;
    localparam int COEF_ADDR_BITS = LINE_BITS + TAP_BITS;
    localparam int COEF_DEPTH     = MAX_LINE * MAX_TAPS;
    localparam int ACC_BITS       = 40;
    localparam int PROD_BITS      = 2 * SAMPLE_BITS;
    localparam int FRAC_BITS      = SAMPLE_BITS - 2;
    localparam int RES_BITS       = ACC_BITS + 1 - FRAC_BITS;
    localparam int TAPS_CFG_BITS  = 5;
    localparam int LEN_CFG_BITS   = 12;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int IN_DATA_BITS   = 48;
    localparam int OUT_DATA_BITS  = 32;

    localparam logic [1:0] KIND_COEF    = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE  = 2'd2;
    localparam logic [1:0] KIND_COMPUTE = 2'd3;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_TAPS   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LENGTH = 2'd1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic                 capture;
        logic                 wr_coef;
        logic                 wr_start;
        logic                 wr_line;
        logic                 rd_start;
        logic                 latch_start;
        logic                 clear_acc;
        logic                 issue;
        logic [TAP_BITS-1:0]  tap_idx;
        logic [LINE_BITS-1:0] last_col;
        logic                 load_out;
    } cmd_t;

    typedef struct packed {
        logic busy;
    } status_t;

endpackage

// ===== src/hpr_ram.sv =====
// ============================================================================
// hpr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module hpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/hpr_ctrl.sv =====
// ============================================================================
// hpr_ctrl
// Controller: configuration registers, item decode and the tap sequencer.
// ============================================================================
module hpr_ctrl (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hpr_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [hpr_pkg::LEN_CFG_BITS-1:0]      cfg_wdata,
    input  hpr_pkg::status_t                      status,
    output hpr_pkg::cmd_t                         cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RDSTART = 3'd1;
    localparam logic [2:0] ST_LATCH   = 3'd2;
    localparam logic [2:0] ST_TAPS    = 3'd3;
    localparam logic [2:0] ST_DRAIN   = 3'd4;
    localparam logic [2:0] ST_FINISH  = 3'd5;

    localparam logic [hpr_pkg::TAPS_CFG_BITS-1:0] TAPS_MAX =
        hpr_pkg::TAPS_CFG_BITS'(hpr_pkg::MAX_TAPS);
    localparam logic [hpr_pkg::LEN_CFG_BITS-1:0] LEN_MAX =
        hpr_pkg::LEN_CFG_BITS'(hpr_pkg::MAX_LINE);

    logic [2:0]                            state_reg, state_next;
    logic [hpr_pkg::TAP_BITS-1:0]          k_reg, k_next;
    logic                                  out_valid_reg, out_valid_next;
    logic [hpr_pkg::TAPS_CFG_BITS-1:0]     taps_reg;
    logic [hpr_pkg::LEN_CFG_BITS-1:0]      len_reg;
    logic [hpr_pkg::TAPS_CFG_BITS-1:0]     taps_eff;
    logic [hpr_pkg::LEN_CFG_BITS-1:0]      len_m1;
    logic [hpr_pkg::LINE_BITS-1:0]         last_col;
    logic                                  accept;
    logic                                  last_tap;
    logic                                  load_out;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign taps_eff = (taps_reg > TAPS_MAX) ? TAPS_MAX : taps_reg;
    assign len_m1   = len_reg - 1'b1;

    always_comb begin
        if (len_reg == '0) begin
            last_col = '0;
        end else if (len_reg > LEN_MAX) begin
            last_col = hpr_pkg::LINE_BITS'(hpr_pkg::MAX_LINE - 1);
        end else begin
            last_col = len_m1[hpr_pkg::LINE_BITS-1:0];
        end
    end

    assign last_tap = ({1'b0, k_reg} == (taps_eff - 1'b1));
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg <= hpr_pkg::TAPS_CFG_BITS'(1);
            len_reg  <= LEN_MAX;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                hpr_pkg::CFG_TAPS:   taps_reg <= cfg_wdata[hpr_pkg::TAPS_CFG_BITS-1:0];
                hpr_pkg::CFG_LENGTH: len_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_axis_tuser == hpr_pkg::KIND_COMPUTE)) begin
                    state_next = ST_RDSTART;
                end
            end
            ST_RDSTART: begin
                state_next = ST_LATCH;
            end
            ST_LATCH: begin
                k_next     = '0;
                state_next = (taps_eff == '0) ? ST_DRAIN : ST_TAPS;
            end
            ST_TAPS: begin
                k_next = k_reg + 1'b1;
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        cmd             = '0;
        cmd.capture     = accept;
        cmd.wr_coef     = accept && (s_axis_tuser == hpr_pkg::KIND_COEF);
        cmd.wr_start    = accept && (s_axis_tuser == hpr_pkg::KIND_START);
        cmd.wr_line     = accept && (s_axis_tuser == hpr_pkg::KIND_SAMPLE);
        cmd.rd_start    = (state_reg == ST_RDSTART);
        cmd.latch_start = (state_reg == ST_LATCH);
        cmd.clear_acc   = (state_reg == ST_LATCH);
        cmd.issue       = (state_reg == ST_TAPS);
        cmd.tap_idx     = k_reg;
        cmd.last_col    = last_col;
        cmd.load_out    = load_out;
    end

endmodule

// ===== src/hpr_datapath.sv =====
// ============================================================================
// hpr_datapath
// Datapath: coefficient, start and line memories, multiply-accumulate,
// rounding with saturation and the result register.
// ============================================================================
module hpr_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [hpr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    input  hpr_pkg::cmd_t                      cmd,
    output hpr_pkg::status_t                   status,
    output logic [hpr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                               m_axis_tuser
);

    localparam int LB = hpr_pkg::LINE_BITS;
    localparam int TB = hpr_pkg::TAP_BITS;
    localparam int SB = hpr_pkg::SAMPLE_BITS;

    localparam logic signed [hpr_pkg::RES_BITS-1:0] RES_HI =
        hpr_pkg::RES_BITS'((1 << (SB - 1)) - 1);
    localparam logic signed [hpr_pkg::RES_BITS-1:0] RES_LO =
        -hpr_pkg::RES_BITS'(1 << (SB - 1));
    localparam logic signed [hpr_pkg::ACC_BITS:0] HALF_LSB =
        (hpr_pkg::ACC_BITS + 1)'(1 << (hpr_pkg::FRAC_BITS - 1));

    logic [LB-1:0]              in_pos;
    logic [TB-1:0]              in_tap;
    hpr_pkg::sample_t           in_sample;
    logic [LB-1:0]              in_start;

    logic [LB-1:0]              pos_reg;
    logic [LB-1:0]              start_reg;
    logic [LB-1:0]              start_rdata;
    hpr_pkg::sample_t           coef_rdata;
    hpr_pkg::sample_t           line_rdata;
    logic [LB:0]                col_sum;
    logic [LB-1:0]              col;
    logic                       rd_valid_reg;
    logic                       prod_valid_reg;
    logic signed [hpr_pkg::PROD_BITS-1:0] prod_reg;
    logic signed [hpr_pkg::ACC_BITS-1:0]  acc_reg;
    logic signed [hpr_pkg::ACC_BITS:0]    rnd;
    logic signed [hpr_pkg::RES_BITS-1:0]  res;
    hpr_pkg::sample_t           sat_value;
    logic                       sat_clip;
    logic [LB-1:0]              out_index_reg;
    hpr_pkg::sample_t           out_value_reg;
    logic                       out_clip_reg;

    assign in_pos    = s_axis_tdata[LB-1:0];
    assign in_tap    = s_axis_tdata[LB+TB-1:LB];
    assign in_sample = s_axis_tdata[LB+TB+SB-1:LB+TB];
    assign in_start  = s_axis_tdata[2*LB+TB+SB-1:LB+TB+SB];

    assign col_sum = {1'b0, start_reg} + (LB+1)'(cmd.tap_idx);
    assign col     = (col_sum > {1'b0, cmd.last_col}) ? cmd.last_col : col_sum[LB-1:0];

    hpr_ram #(.WIDTH(LB), .DEPTH(hpr_pkg::MAX_LINE)) u_start_ram (
        .aclk  (aclk),
        .we    (cmd.wr_start),
        .waddr (in_pos),
        .wdata (in_start),
        .re    (cmd.rd_start),
        .raddr (pos_reg),
        .rdata (start_rdata)
    );

    hpr_ram #(.WIDTH(SB), .DEPTH(hpr_pkg::COEF_DEPTH)) u_coef_ram (
        .aclk  (aclk),
        .we    (cmd.wr_coef),
        .waddr ({in_pos, in_tap}),
        .wdata (in_sample),
        .re    (cmd.issue),
        .raddr ({pos_reg, cmd.tap_idx}),
        .rdata (coef_rdata)
    );

    hpr_ram #(.WIDTH(SB), .DEPTH(hpr_pkg::MAX_LINE)) u_line_ram (
        .aclk  (aclk),
        .we    (cmd.wr_line),
        .waddr (in_pos),
        .wdata (in_sample),
        .re    (cmd.issue),
        .raddr (col),
        .rdata (line_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= cmd.issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pos_reg <= in_pos;
        end
        if (cmd.latch_start) begin
            start_reg <= start_rdata;
        end
        prod_reg <= coef_rdata * line_rdata;
        if (cmd.clear_acc) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_reg + hpr_pkg::ACC_BITS'(prod_reg);
        end
    end

    assign status.busy = rd_valid_reg || prod_valid_reg;

    assign rnd = (hpr_pkg::ACC_BITS + 1)'(acc_reg) + HALF_LSB;
    assign res = rnd[hpr_pkg::ACC_BITS:hpr_pkg::FRAC_BITS];

    always_comb begin
        if (res > RES_HI) begin
            sat_value = RES_HI[SB-1:0];
            sat_clip  = 1'b1;
        end else if (res < RES_LO) begin
            sat_value = RES_LO[SB-1:0];
            sat_clip  = 1'b1;
        end else begin
            sat_value = res[SB-1:0];
            sat_clip  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_index_reg <= pos_reg;
            out_value_reg <= sat_value;
            out_clip_reg  <= sat_clip;
        end
    end

    assign m_axis_tdata = {(hpr_pkg::OUT_DATA_BITS - LB - SB)'(0), out_value_reg, out_index_reg};
    assign m_axis_tuser = out_clip_reg;

endmodule

// ===== src/horizontal_polyphase_resampler.sv =====
// ============================================================================
// horizontal_polyphase_resampler
// Filters one image line with a per-output polyphase coefficient table.
// ============================================================================
// The input stream carries four kinds of beat, selected by s_axis_tuser:
// coefficient writes, window start writes, source sample writes and compute
// requests. A write beat produces no result. A compute beat for output j
// reads the window start of j, then runs one multiply-accumulate per tap
// through the coefficient and line memories and returns one result beat
// carrying j, the rounded and saturated value and a saturation flag in
// m_axis_tuser.
// A compute beat occupies the block until its result is loaded: the single
// shared multiply-accumulate unit reads one coefficient and one sample per
// cycle once the window start is latched, and then the pipeline drains.
// The configuration channel is always ready and sets the tap count and the
// source line length; write it only while the block is idle.
// The result sits in an output register, so write beats are still taken while
// a result waits; a further compute beat holds in its final cycle until the
// receiver takes the earlier result. Reset returns the controller to idle,
// clears the output valid and restores one tap and full line length; memory
// contents are kept and must be written before use.
module horizontal_polyphase_resampler (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // position[10:0], tap[14:11], sample_or_coeff[30:15], start_column[41:31]
    input  logic [hpr_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // result_index[10:0], result_value[26:11]
    output logic [hpr_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    // clipped[0]
    output logic                                 m_axis_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hpr_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [hpr_pkg::LEN_CFG_BITS-1:0]     cfg_wdata
);

    hpr_pkg::cmd_t    cmd;
    hpr_pkg::status_t status;

    hpr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .status        (status),
        .cmd           (cmd)
    );

    hpr_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tdata (s_axis_tdata),
        .cmd          (cmd),
        .status       (status),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

endmodule

// ===== src/hpr_checker.sv =====
// ============================================================================
// hpr_checker
// Port-level checks for the horizontal polyphase resampler.
// ============================================================================
module hpr_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [hpr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input logic                               m_axis_tuser
);

    // A result beat that is stalled keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A saturated result sits at one end of the sample range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[26:11] == 16'h7FFF) || (m_axis_tdata[26:11] == 16'h8000))
        else $error("clipped flag without saturated value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[31:27] == 5'd0))
        else $error("result padding bits not zero");

    // A new result needs a compute beat accepted earlier, so its valid never rises
    // while the input side was ready both in that cycle and in the one before.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> !s_axis_tready || $past(!s_axis_tready))
        else $error("result appeared without a compute in progress");

endmodule

bind horizontal_polyphase_resampler hpr_checker u_hpr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/horizontal_polyphase_resampler_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// horizontal_polyphase_resampler_tb
// Self-checking testbench for the horizontal polyphase resampler.
// ============================================================================
// A table of directed beats runs first. It covers full-scale samples and
// coefficients, saturation in both directions, rounding of a half LSB in both
// directions, and the last column and output index. Random phases follow, and
// each phase uses its own tap count and line length. Zero taps, zero length,
// oversized values and writes to unused register indexes are among them. Most
// random beats form complete load-then-compute sequences for a small set of
// outputs. A few sequences stop before the compute, and some writes are fully
// random. No compute ever reads a coefficient, window start or sample that
// was never written. An internal filter model predicts every result the table
// does not give. Both streams idle in random bursts, and at one point the
// receiver holds off for a long stretch while the input keeps offering beats.
// ============================================================================
module horizontal_polyphase_resampler_tb;

    localparam logic [hpr_pkg::CFG_ADDR_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [hpr_pkg::CFG_ADDR_BITS-1:0] CFG_SPARE_B = 2'd3;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASES          = 7;

    typedef struct packed {
        logic [hpr_pkg::LINE_BITS-1:0] index;
        logic signed [15:0]            value;
        logic                          clipped;
    } filtered_t;

    typedef struct packed {
        logic [1:0]                    kind;
        logic [hpr_pkg::LINE_BITS-1:0] position;
        logic [hpr_pkg::TAP_BITS-1:0]  tap;
        logic signed [15:0]            value;
        logic [hpr_pkg::LINE_BITS-1:0] start;
        logic                          golden;
        filtered_t                     golden_result;
    } beat_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [hpr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata;
    logic [1:0]                         s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [hpr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                               m_axis_tuser;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [hpr_pkg::CFG_ADDR_BITS-1:0]  cfg_addr;
    logic [hpr_pkg::LEN_CFG_BITS-1:0]   cfg_wdata;

    logic signed [15:0]            coef_mem [0:hpr_pkg::COEF_DEPTH-1];
    logic [hpr_pkg::LINE_BITS-1:0] window_start [0:hpr_pkg::MAX_LINE-1];
    logic signed [15:0]            line_mem [0:hpr_pkg::MAX_LINE-1];
    bit                            coef_loaded [0:hpr_pkg::COEF_DEPTH-1];
    bit                            start_loaded [0:hpr_pkg::MAX_LINE-1];
    bit                            line_loaded [0:hpr_pkg::MAX_LINE-1];
    logic [hpr_pkg::TAPS_CFG_BITS-1:0] taps_reg;
    logic [hpr_pkg::LEN_CFG_BITS-1:0]  length_reg;

    filtered_t pending_outputs [$];
    beat_t     directed_beats [$];
    int        errors;
    int        beats_sent;
    int        idle_cycles;
    bit        steady;
    bit        hold_off_request;

    horizontal_polyphase_resampler DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic int active_taps();
        return (taps_reg > hpr_pkg::MAX_TAPS) ? hpr_pkg::MAX_TAPS : int'(taps_reg);
    endfunction

    function automatic int active_length();
        if (length_reg == 0) begin
            return 1;
        end
        return (length_reg > hpr_pkg::MAX_LINE) ? hpr_pkg::MAX_LINE : int'(length_reg);
    endfunction

    function automatic int window_column(input logic [hpr_pkg::LINE_BITS-1:0] j, input int k);
        int col;
        col = int'(window_start[j]) + k;
        return (col > active_length() - 1) ? active_length() - 1 : col;
    endfunction

    function automatic filtered_t filter_output(input logic [hpr_pkg::LINE_BITS-1:0] j);
        filtered_t          r;
        logic signed [39:0] acc;
        logic signed [31:0] prod;
        logic signed [40:0] biased;
        logic signed [26:0] scaled;
        int                 k;
        acc = '0;
        for (k = 0; k < active_taps(); k++) begin
            prod = coef_mem[int'(j) * hpr_pkg::MAX_TAPS + k] * line_mem[window_column(j, k)];
            acc = acc + {{8{prod[31]}}, prod};
        end
        biased = {acc[39], acc} + 41'sd8192;
        scaled = biased[40:14];
        r.index = j;
        r.clipped = 1'b1;
        if (scaled > 27'sd32767) begin
            r.value = 16'sd32767;
        end else if (scaled < -27'sd32768) begin
            r.value = -16'sd32768;
        end else begin
            r.value = scaled[15:0];
            r.clipped = 1'b0;
        end
        return r;
    endfunction

    function automatic beat_t make_beat(input logic [1:0] kind, input int position,
                                        input int tap, input int value, input int start);
        beat_t b;
        b = '0;
        b.kind = kind;
        b.position = position[hpr_pkg::LINE_BITS-1:0];
        b.tap = tap[hpr_pkg::TAP_BITS-1:0];
        b.value = value[15:0];
        b.start = start[hpr_pkg::LINE_BITS-1:0];
        return b;
    endfunction

    function automatic beat_t with_result(input beat_t b, input int index, input int value,
                                          input bit clipped);
        beat_t g;
        g = b;
        g.golden = 1'b1;
        g.golden_result.index = index[hpr_pkg::LINE_BITS-1:0];
        g.golden_result.value = value[15:0];
        g.golden_result.clipped = clipped;
        return g;
    endfunction

    function automatic int rand_q14();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2, 3, 4: return int'($urandom_range(0, 8191)) - 4096;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic take_beat(input beat_t b);
        case (b.kind)
            hpr_pkg::KIND_COEF: begin
                coef_mem[{b.position, b.tap}] = b.value;
                coef_loaded[{b.position, b.tap}] = 1'b1;
            end
            hpr_pkg::KIND_START: begin
                window_start[b.position] = b.start;
                start_loaded[b.position] = 1'b1;
            end
            hpr_pkg::KIND_SAMPLE: begin
                line_mem[b.position] = b.value;
                line_loaded[b.position] = 1'b1;
            end
            default: begin
                if (b.golden) begin
                    pending_outputs.push_back(b.golden_result);
                end else begin
                    pending_outputs.push_back(filter_output(b.position));
                end
            end
        endcase
    endtask

    task automatic send_beat(input beat_t b);
        if (!steady && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_axis_tdata <= {6'b0, b.start, b.value, b.tap, b.position};
        s_axis_tuser <= b.kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        take_beat(b);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [hpr_pkg::CFG_ADDR_BITS-1:0] addr,
                                  input int data);
        cfg_addr <= addr;
        cfg_wdata <= data[hpr_pkg::LEN_CFG_BITS-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (addr == hpr_pkg::CFG_TAPS) begin
            taps_reg = data[hpr_pkg::TAPS_CFG_BITS-1:0];
        end else if (addr == hpr_pkg::CFG_LENGTH) begin
            length_reg = data[hpr_pkg::LEN_CFG_BITS-1:0];
        end
        @(negedge aclk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Loads whatever output j still lacks, refreshes some of it with new
    // values, and then asks for the output unless the sequence is cut short.
    task automatic run_output(input logic [hpr_pkg::LINE_BITS-1:0] j, input bit complete);
        int k;
        int col;
        int start;
        if (!start_loaded[j] || $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 7))
                0: start = $urandom_range(0, hpr_pkg::MAX_LINE - 1);
                1: start = $urandom_range(hpr_pkg::MAX_LINE - 16, hpr_pkg::MAX_LINE - 1);
                default: start = $urandom_range(0, 63);
            endcase
            send_beat(make_beat(hpr_pkg::KIND_START, int'(j), $urandom_range(0, 15),
                                rand_q14(), start));
        end
        for (k = 0; k < active_taps(); k++) begin
            if (!coef_loaded[int'(j) * hpr_pkg::MAX_TAPS + k] || $urandom_range(0, 2) == 0) begin
                send_beat(make_beat(hpr_pkg::KIND_COEF, int'(j), k, rand_q14(),
                                    $urandom_range(0, 2047)));
            end
        end
        for (k = 0; k < active_taps(); k++) begin
            col = window_column(j, k);
            if (!line_loaded[col] || $urandom_range(0, 7) == 0) begin
                send_beat(make_beat(hpr_pkg::KIND_SAMPLE, col, $urandom_range(0, 15),
                                    rand_q14(), $urandom_range(0, 2047)));
            end
        end
        if (complete) begin
            send_beat(make_beat(hpr_pkg::KIND_COMPUTE, int'(j), $urandom_range(0, 15),
                                int'($urandom_range(0, 65535)), $urandom_range(0, 2047)));
        end
    endtask

    initial begin : result_sink
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_request = 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        filtered_t          want;
        logic signed [15:0] got_value;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_value = m_axis_tdata[26:11];
            if (pending_outputs.size() == 0) begin
                $error("result beat with nothing expected: tdata=%h tuser=%b",
                       m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = pending_outputs.pop_front();
                if (m_axis_tdata[10:0] !== want.index) begin
                    $error("result_index: expected %0d, got %0d", want.index,
                           m_axis_tdata[10:0]);
                    errors++;
                end
                if (got_value !== want.value) begin
                    $error("result_value: expected %0d, got %0d", want.value, got_value);
                    errors++;
                end
                if (m_axis_tuser !== want.clipped) begin
                    $error("clipped: expected %0d, got %0d", want.clipped, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int                            p;
        int                            quota;
        int                            pick;
        logic [hpr_pkg::LINE_BITS-1:0] j;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = hpr_pkg::KIND_COEF;
        cfg_valid = 1'b0;
        cfg_addr = hpr_pkg::CFG_TAPS;
        cfg_wdata = '0;
        errors = 0;
        beats_sent = 0;
        idle_cycles = 0;
        steady = 1'b0;
        hold_off_request = 1'b0;
        taps_reg = hpr_pkg::TAPS_CFG_BITS'(1);
        length_reg = hpr_pkg::LEN_CFG_BITS'(hpr_pkg::MAX_LINE);
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_beats.push_back(make_beat(hpr_pkg::KIND_SAMPLE, 0, 0, 16384, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_SAMPLE, 2047, 15, -32768, 2047));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_SAMPLE, 5, 0, 1, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_SAMPLE, 6, 0, -1, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_SAMPLE, 1, 0, 32767, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_COEF, 0, 0, 16384, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_START, 0, 0, 0, 0));
        directed_beats.push_back(with_result(make_beat(hpr_pkg::KIND_COMPUTE, 0, 0, 0, 0),
                                             0, 16384, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_COEF, 2047, 0, -32768, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_START, 2047, 0, 0, 2047));
        directed_beats.push_back(with_result(make_beat(hpr_pkg::KIND_COMPUTE, 2047, 15, -1,
                                                       2047), 2047, 32767, 1));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_COEF, 1, 0, 32767, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_START, 1, 0, 0, 2047));
        directed_beats.push_back(with_result(make_beat(hpr_pkg::KIND_COMPUTE, 1, 0, 0, 0),
                                             1, -32768, 1));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_COEF, 3, 0, 8192, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_START, 3, 0, 0, 5));
        directed_beats.push_back(with_result(make_beat(hpr_pkg::KIND_COMPUTE, 3, 0, 0, 0),
                                             3, 1, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_COEF, 4, 0, 8192, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_START, 4, 0, 0, 6));
        directed_beats.push_back(with_result(make_beat(hpr_pkg::KIND_COMPUTE, 4, 0, 0, 0),
                                             4, 0, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_COEF, 2047, 15, 32767, 2047));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_COEF, 5, 0, -16384, 0));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_START, 5, 0, 0, 1));
        directed_beats.push_back(make_beat(hpr_pkg::KIND_COMPUTE, 5, 0, 0, 0));
        foreach (directed_beats[i]) begin
            send_beat(directed_beats[i]);
        end
        settle();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_register(hpr_pkg::CFG_TAPS, 4);
                    write_register(hpr_pkg::CFG_LENGTH, 2048);
                    quota = 220;
                end
                1: begin
                    write_register(hpr_pkg::CFG_TAPS, 16);
                    write_register(hpr_pkg::CFG_LENGTH, 100);
                    hold_off_request = 1'b1;
                    quota = 260;
                end
                2: begin
                    write_register(hpr_pkg::CFG_TAPS, 0);
                    write_register(hpr_pkg::CFG_LENGTH, 0);
                    quota = 120;
                end
                3: begin
                    write_register(hpr_pkg::CFG_TAPS, 'hFFF);
                    write_register(hpr_pkg::CFG_LENGTH, 'hFFF);
                    quota = 260;
                end
                4: begin
                    write_register(hpr_pkg::CFG_TAPS, 1);
                    write_register(hpr_pkg::CFG_LENGTH, 1);
                    quota = 150;
                end
                5: begin
                    write_register(hpr_pkg::CFG_TAPS, 17);
                    write_register(hpr_pkg::CFG_LENGTH, 2047);
                    quota = 220;
                end
                default: begin
                    write_register(hpr_pkg::CFG_TAPS,
                                   int'($urandom_range(1, hpr_pkg::MAX_TAPS)));
                    write_register(hpr_pkg::CFG_LENGTH,
                                   int'($urandom_range(1, hpr_pkg::MAX_LINE)));
                    steady = 1'b1;
                    quota = 200;
                end
            endcase
            // Writes to unused indexes must leave both registers unchanged.
            write_register(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                           int'($urandom_range(0, 4095)));
            cfg_valid <= 1'b0;
            quota = beats_sent + quota;
            while (beats_sent < quota) begin
                pick = $urandom_range(0, 9);
                j = hpr_pkg::LINE_BITS'(($urandom_range(0, 7) == 0)
                                        ? $urandom_range(0, hpr_pkg::MAX_LINE - 1)
                                        : $urandom_range(0, 31));
                if (pick == 0) begin
                    send_beat(make_beat(2'($urandom_range(0, 2)), $urandom_range(0, 2047),
                                        $urandom_range(0, 15), rand_q14(),
                                        $urandom_range(0, 2047)));
                end else begin
                    run_output(j, pick != 1);
                end
            end
            settle();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/hpr_pkg.sv
src/hpr_ram.sv
src/hpr_ctrl.sv
src/hpr_datapath.sv
src/horizontal_polyphase_resampler.sv
src/hpr_checker.sv
dv/horizontal_polyphase_resampler_tb.sv
